@@ sv/sha_pkg.sv @@
// Package for the SHA-256 message digest block.
// Holds round constants, initial hash words, shared types and a helper function.
// No dependencies.
package sha_pkg;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_ROUNDS,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] InitialHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte = 8'h80;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ sv/sha_queue.sv @@
// Short item queue between the byte front end and the compression engine.
// Depends on sha_pkg.
module sha_queue #(
   parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sha_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output sha_pkg::item_type pop_item,
   output logic              empty
);
   import sha_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type          slots_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slots_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = do_pop ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ sv/sha_engine.sv @@
// Back end: collects bytes into blocks, runs 64 rounds per block, pads and emits the digest.
// Depends on sha_pkg.
module sha_engine (
   input  logic              clock,
   input  logic              reset,
   input  sha_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_take,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last_word,
   output logic              rsp_empty,
   input  logic              pop
);
   import sha_pkg::*;

   state_type     state_ff, state_in;
   logic [31:0]   block_ff [16];
   logic [31:0]   sched_ff [16];
   logic [31:0]   hash_ff [8];
   logic [31:0]   work_ff [8];
   logic [60:0]   total_ff, total_in;
   logic [6:0]    round_ff, round_in;
   logic          final_ff, final_in;
   logic          last_ff, last_in;
   logic [1:0]    pad_ff, pad_in;
   logic [2:0]    emit_ff, emit_in;

   logic [5:0]    pos;
   logic [3:0]    slot;
   logic [31:0]   w, t1, t2, x15, x2, s0, s1;
   logic          start_block;
   logic          write_byte;
   logic [7:0]    wbyte;
   logic [5:0]    wpos;

   assign pos  = total_ff[5:0];
   assign slot = round_ff[3:0];

   always_comb begin
      x15 = sched_ff[slot + 4'd1];
      x2  = sched_ff[slot + 4'd14];
      s0  = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
      s1  = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
      if (round_ff < 7'd16) begin
         w = block_ff[slot];
      end else begin
         w = sched_ff[slot] + s0 + sched_ff[slot + 4'd9] + s1;
      end
      t1 = work_ff[7] + (ror32(work_ff[4], 6) ^ ror32(work_ff[4], 11) ^ ror32(work_ff[4], 25))
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + RoundK[round_ff[5:0]] + w;
      t2 = (ror32(work_ff[0], 2) ^ ror32(work_ff[0], 13) ^ ror32(work_ff[0], 22))
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
   end

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      round_in    = round_ff;
      final_in    = final_ff;
      last_in     = last_ff;
      pad_in      = pad_ff;
      emit_in     = emit_ff;
      item_take   = 1'b0;
      start_block = 1'b0;
      write_byte  = 1'b0;
      wbyte       = item.msg_byte;
      wpos        = pos;
      rsp_empty   = 1'b1;
      case (state_ff)
         ST_COLLECT: begin
            if (item_valid) begin
               item_take = 1'b1;
               if (item.byte_present) begin
                  write_byte = 1'b1;
                  total_in   = total_ff + 61'd1;
                  last_in    = item.end_of_message;
                  if (pos == 6'd63) begin
                     start_block = 1'b1;
                     final_in    = 1'b0;
                     state_in    = ST_ROUNDS;
                  end else if (item.end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (item.end_of_message) begin
                  last_in  = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUNDS: begin
            round_in = round_ff + 7'd1;
            if (round_ff == 7'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            round_in = '0;
            if (final_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end else if (last_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_COLLECT;
            end
         end
         ST_PAD: begin
            // Terminator and zero fill go into the block words in one step.
            pad_in      = 2'd0;
            start_block = 1'b1;
            final_in    = 1'b0;
            state_in    = ST_ROUNDS;
            if (pad_ff == 2'd1 || pos < 6'd56) begin
               final_in = 1'b1;
            end else begin
               pad_in = 2'd1;
            end
         end
         ST_EMIT: begin
            rsp_empty = 1'b0;
            if (pop) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  total_in = '0;
                  last_in  = 1'b0;
                  final_in = 1'b0;
                  pad_in   = 2'd0;
                  state_in = ST_COLLECT;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   assign rsp_digest_word = hash_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         total_ff <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         last_ff  <= 1'b0;
         pad_ff   <= 2'd0;
         emit_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= InitialHash[i];
            work_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         round_ff <= round_in;
         final_ff <= final_in;
         last_ff  <= last_in;
         pad_ff   <= pad_in;
         emit_ff  <= emit_in;
         if (start_block) begin
            for (int i = 0; i < 8; i++) begin
               work_ff[i] <= hash_ff[i];
            end
         end
         if (state_ff == ST_ROUNDS) begin
            work_ff[7] <= work_ff[6];
            work_ff[6] <= work_ff[5];
            work_ff[5] <= work_ff[4];
            work_ff[4] <= work_ff[3] + t1;
            work_ff[3] <= work_ff[2];
            work_ff[2] <= work_ff[1];
            work_ff[1] <= work_ff[0];
            work_ff[0] <= t1 + t2;
         end
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= hash_ff[i] + work_ff[i];
            end
         end
         if (state_ff == ST_EMIT && pop && emit_ff == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= InitialHash[i];
            end
         end
      end
      if (state_ff == ST_ROUNDS) begin
         sched_ff[slot] <= w;
      end
      if (write_byte) begin
         case (wpos[1:0])
            2'd0: block_ff[wpos[5:2]][31:24] <= wbyte;
            2'd1: block_ff[wpos[5:2]][23:16] <= wbyte;
            2'd2: block_ff[wpos[5:2]][15:8]  <= wbyte;
            default: block_ff[wpos[5:2]][7:0] <= wbyte;
         endcase
      end
      if (state_ff == ST_PAD) begin
         for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (pad_ff == 2'd1) begin
                  block_ff[i][31-8*j -: 8] <= 8'h00;
               end else if (6'(4*i+j) == pos) begin
                  block_ff[i][31-8*j -: 8] <= PadByte;
               end else if (6'(4*i+j) > pos) begin
                  block_ff[i][31-8*j -: 8] <= 8'h00;
               end
            end
         end
         if (pad_ff == 2'd1 || pos < 6'd56) begin
            block_ff[14] <= total_ff[60:29];
            block_ff[15] <= {total_ff[28:0], 3'b000};
         end
      end
   end

endmodule

@@ sv/sha256_message_digest.sv @@
// Top level of the SHA-256 message digest block.
// Depends on sha_pkg, sha_queue and sha_engine.
// Bytes enter a four-item queue and are taken by the engine at one per cycle
// while it collects, not while a block runs, pads or drains; each 64th byte starts
// a block of 64 rounds on one shared round unit and one chain add. At message end
// padding costs one or two further blocks; the eight digest words drain one per pop.
module sha256_message_digest #(
   parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   item_type in_item, q_item;
   logic     q_empty, q_take;

   assign in_item = '{msg_byte: req_msg_byte, byte_present: req_byte_present,
                      end_of_message: req_end_of_message};

   sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (in_item),
      .full      (full),
      .pop       (q_take),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   sha_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .item            (q_item),
      .item_valid      (!q_empty),
      .item_take       (q_take),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .rsp_empty       (empty),
      .pop             (pop)
   );

endmodule

@@ test/sha256_message_digest_tb.sv @@
// Testbench for the SHA-256 message digest block: streams messages byte by byte
// and checks every digest word against a SHA-256 predictor held in a scoreboard class.
// Depends on sha_pkg and sha256_message_digest.
module sha256_message_digest_tb;
   import sha_pkg::*;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   class digest_scoreboard;
      logic [31:0] chain [8];
      logic [7:0]  block [64];
      logic [60:0] byte_count;
      digest_entry_type pending [$];
      int errors;

      function new();
         chain = InitialHash;
         byte_count = 0;
         errors = 0;
         foreach (block[i]) block[i] = 0;
      endfunction

      function automatic logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++)
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] += v[i];
      endfunction

      function void note_item(logic [7:0] data, logic present, logic finish);
         int pos;
         logic [63:0] bits;
         digest_entry_type e;
         if (present) begin
            pos = int'(byte_count[5:0]);
            block[pos] = data;
            byte_count++;
            if (pos == 63) compress();
         end
         if (!finish) return;
         pos = int'(byte_count[5:0]);
         block[pos] = PadByte;
         pos++;
         if (pos > 56) begin
            while (pos < 64) begin
               block[pos] = 0;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < 56) begin
            block[pos] = 0;
            pos++;
         end
         bits = {byte_count, 3'b000};
         for (int i = 0; i < 8; i++) block[56+i] = bits[63-8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            e.word = chain[i];
            e.index = 3'(i);
            e.last = (i == 7);
            pending.push_back(e);
         end
         chain = InitialHash;
         byte_count = 0;
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_entry_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, word);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (word !== e.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
            errors++;
         end
         if (index !== e.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time, e.index, index);
            errors++;
         end
         if (last !== e.last) begin
            $display("%0t: last_word expected %0d actual %0d", $time, e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        full;
   logic [7:0]  req_msg_byte = 0;
   logic        req_byte_present = 0;
   logic        req_end_of_message = 0;
   logic        empty;
   logic        pop = 0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard board = new();
   bit sending_done = 0;
   int hold_cycles = 0;

   sha256_message_digest dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic send_item(logic [7:0] data, logic present, logic finish);
      int gap;
      bit taken;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_msg_byte <= data;
      req_byte_present <= present;
      req_end_of_message <= finish;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end
      board.note_item(data, present, finish);
   endtask

   task automatic send_message(int length, int mode);
      logic [7:0] data;
      for (int i = 0; i < length; i++) begin
         data = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hff : 8'($urandom_range(0, 255));
         if (i == length - 1 && $urandom_range(0, 1))
            send_item(data, 1, 1);
         else
            send_item(data, 1, 0);
      end
      if (length == 0 || board.byte_count != 0)
         send_item(8'($urandom_range(0, 255)), 0, 1);
   endtask

   initial begin
      int length;
      repeat (2) @(posedge clock);
      reset <= 0;
      send_message(0, 2);
      send_message(3, 2);
      send_message(1, 0);
      send_message(1, 1);
      send_message(55, 2);
      send_message(56, 1);
      send_message(63, 0);
      send_message(64, 2);
      // Two items with no byte and no end change nothing.
      send_item(8'h5a, 0, 0);
      send_item(8'ha5, 0, 0);
      send_message(2, 2);
      hold_cycles = 300;
      send_message(20, 2);
      for (int n = 0; n < 8; n++) begin
         length = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                               : $urandom_range(0, 12);
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 0, 0);
         send_message(length, 2);
      end
      push <= 0;
      sending_done = 1;
   end

   initial begin
      int gap;
      bit taken;
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            pop <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         taken = 0;
         while (!taken) begin
            @(negedge clock);
            taken = !empty;
            word  = rsp_digest_word;
            index = rsp_word_index;
            last  = rsp_last_word;
            @(posedge clock);
         end
         board.check_word(word, index, last);
      end
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #40000000;
      $display("simulation failed");
      $finish;
   end
endmodule
